// ===== sv/cda_pkg.sv =====
`default_nettype none

package cda_pkg;

  localparam int unsigned CountW = 22;
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned YlenW  = 9;

  typedef logic [CountW-1:0] count_t;
  typedef logic [YearW-1:0]  year_t;
  typedef logic [MonthW-1:0] month_t;
  typedef logic [DayW-1:0]   day_t;
  typedef logic [YlenW-1:0]  ylen_t;

  localparam logic [1:0] CMD_BETWEEN = 2'd0;
  localparam logic [1:0] CMD_AFTER   = 2'd1;
  localparam logic [1:0] CMD_BEFORE  = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ORDER    = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;
  localparam logic [1:0] STATUS_INVALID  = 2'd3;

  localparam year_t  YEAR_MAX    = 14'd9999;
  localparam month_t MONTH_MAX   = 4'd12;
  localparam count_t LAST_SERIAL = 22'd3652058;

  // Divides by 100 through a multiply by 5243 / 2^19, which is exact for
  // every 14-bit year, then applies the century rule.
  function automatic logic leap_year(input year_t y);
    logic [26:0] prod;
    logic [7:0]  cent;
    year_t       rem;
    prod = 27'(y) * 27'd5243;
    cent = prod[26:19];
    rem  = y - 14'(cent) * 14'd100;
    return (y[1:0] == 2'b00) && ((rem != '0) || (cent[1:0] == 2'b00));
  endfunction

  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic ylen_t year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

`default_nettype wire

// ===== sv/calendar_date_arithmetic_core.sv =====
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+--------------------------------------------
// request   | in        | start, busy        | cmd_i, start_*_i, end_*_i, day_count_i
// result    | out       | done_o (strobe)    | days_between_o, result_*_o, status_o
//
// A request is taken at a rising edge with start high and busy low. One shared adder
// then walks the calendar one year or one month per cycle, turning dates into serial
// day numbers and back. Busy therefore grows with the start year plus the end year for
// a day count, or plus the result year for a date; an invalid date ends in the check
// states. Reset is asynchronous and returns to idle. done_o marks the result for
// exactly one cycle; nothing can stall it.
module calendar_date_arithmetic_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  wire  [1:0]           cmd_i,
  input  wire  cda_pkg::day_t   start_day_i,
  input  wire  cda_pkg::month_t start_month_i,
  input  wire  cda_pkg::year_t  start_year_i,
  input  wire  cda_pkg::day_t   end_day_i,
  input  wire  cda_pkg::month_t end_month_i,
  input  wire  cda_pkg::year_t  end_year_i,
  input  wire  cda_pkg::count_t day_count_i,
  output logic                 done_o,
  output cda_pkg::count_t       days_between_o,
  output cda_pkg::day_t         result_day_o,
  output cda_pkg::month_t       result_month_o,
  output cda_pkg::year_t        result_year_o,
  output logic [1:0]           status_o
);
  import cda_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHKS = 4'd1;  // check the start date
  localparam logic [3:0] S_CHKE = 4'd2;  // check the end date
  localparam logic [3:0] S_TYR  = 4'd3;  // date to serial, year walk
  localparam logic [3:0] S_TMO  = 4'd4;  // date to serial, month walk
  localparam logic [3:0] S_DIFF = 4'd5;  // end serial minus start serial
  localparam logic [3:0] S_OFS  = 4'd6;  // apply the day offset
  localparam logic [3:0] S_FYR  = 4'd7;  // serial to date, year walk
  localparam logic [3:0] S_FMO  = 4'd8;  // serial to date, month walk

  logic [3:0] state_q, state_d;
  logic       side_q, side_d;      // low while converting the start date
  logic       done_q, done_d;

  logic [1:0] cmd_q;
  day_t       sd_q, ed_q;
  month_t     sm_q, em_q;
  year_t      sy_q, ey_q;
  count_t     cnt_q;

  count_t     acc_q, acc_d;
  count_t     s0_q, s0_d;
  year_t      yr_q, yr_d;
  month_t     mo_q, mo_d;

  count_t     out_between_q, out_between_d;
  day_t       out_day_q, out_day_d;
  month_t     out_month_q, out_month_d;
  year_t      out_year_q, out_year_d;
  logic [1:0] out_status_q, out_status_d;

  // Calendar lookup shared by every state: the year and month come from the
  // request while checking dates and from the walk counters otherwise.
  year_t  yr_sel;
  month_t mo_sel;
  day_t   day_sel;
  logic   leap_w;
  day_t   mlen_w;
  ylen_t  ylen_w;
  logic   date_ok;

  year_t  tgt_y;
  month_t tgt_m;
  day_t   tgt_d;

  // The shared adder of the core, used by every walk, difference and offset state.
  count_t      opnd;
  logic        sub;
  logic [22:0] sum;
  logic        accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  assign tgt_y = side_q ? ey_q : sy_q;
  assign tgt_m = side_q ? em_q : sm_q;
  assign tgt_d = side_q ? ed_q : sd_q;

  always_comb begin
    case (state_q)
      S_CHKS: begin
        yr_sel  = sy_q;
        mo_sel  = sm_q;
        day_sel = sd_q;
      end
      S_CHKE: begin
        yr_sel  = ey_q;
        mo_sel  = em_q;
        day_sel = ed_q;
      end
      default: begin
        yr_sel  = yr_q;
        mo_sel  = mo_q;
        day_sel = tgt_d;
      end
    endcase
  end

  assign leap_w  = leap_year(yr_sel);
  assign mlen_w  = month_len(mo_sel, leap_w);
  assign ylen_w  = year_len(leap_w);
  assign date_ok = (yr_sel != '0) && (yr_sel <= YEAR_MAX) &&
                   (mo_sel != '0) && (mo_sel <= MONTH_MAX) &&
                   (day_sel != '0) && (day_sel <= mlen_w);

  always_comb begin
    opnd = '0;
    sub  = 1'b0;
    case (state_q)
      S_TYR:  opnd = count_t'(ylen_w);
      S_TMO:  opnd = (mo_q == tgt_m) ? count_t'(tgt_d - 5'd1) : count_t'(mlen_w);
      S_DIFF: begin
        opnd = s0_q;
        sub  = 1'b1;
      end
      S_OFS: begin
        opnd = cnt_q;
        sub  = (cmd_q == CMD_BEFORE);
      end
      S_FYR: begin
        opnd = count_t'(ylen_w);
        sub  = 1'b1;
      end
      S_FMO: begin
        opnd = count_t'(mlen_w);
        sub  = 1'b1;
      end
      default: begin
        opnd = '0;
        sub  = 1'b0;
      end
    endcase
  end

  // When subtracting, the top bit is high exactly when no borrow occurred.
  assign sum = {1'b0, acc_q} + {1'b0, (sub ? ~opnd : opnd)} + 23'(sub);

  always_comb begin
    state_d       = state_q;
    side_d        = side_q;
    done_d        = 1'b0;
    acc_d         = acc_q;
    s0_d          = s0_q;
    yr_d          = yr_q;
    mo_d          = mo_q;
    out_between_d = out_between_q;
    out_day_d     = out_day_q;
    out_month_d   = out_month_q;
    out_year_d    = out_year_q;
    out_status_d  = out_status_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CHKS;
          side_d  = 1'b0;
        end
      end
      S_CHKS: begin
        acc_d = '0;
        yr_d  = 14'd1;
        if (!(cmd_q inside {CMD_BETWEEN, CMD_AFTER, CMD_BEFORE}) || !date_ok) begin
          state_d      = S_IDLE;
          done_d       = 1'b1;
          out_status_d = STATUS_INVALID;
        end else if (cmd_q == CMD_BETWEEN) begin
          state_d = S_CHKE;
        end else begin
          state_d = S_TYR;
        end
      end
      S_CHKE: begin
        if (!date_ok) begin
          state_d      = S_IDLE;
          done_d       = 1'b1;
          out_status_d = STATUS_INVALID;
        end else begin
          state_d = S_TYR;
        end
      end
      S_TYR: begin
        if (yr_q == tgt_y) begin
          mo_d    = 4'd1;
          state_d = S_TMO;
        end else begin
          acc_d = sum[21:0];
          yr_d  = yr_q + 14'd1;
        end
      end
      S_TMO: begin
        if (mo_q == tgt_m) begin
          // The day of month was added in this cycle; the serial is complete.
          if (!side_q) begin
            s0_d = sum[21:0];
            if (cmd_q == CMD_BETWEEN) begin
              side_d  = 1'b1;
              acc_d   = '0;
              yr_d    = 14'd1;
              state_d = S_TYR;
            end else begin
              acc_d   = sum[21:0];
              state_d = S_OFS;
            end
          end else begin
            acc_d   = sum[21:0];
            state_d = S_DIFF;
          end
        end else begin
          acc_d = sum[21:0];
          mo_d  = mo_q + 4'd1;
        end
      end
      S_DIFF: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (!sum[22]) begin
          out_status_d = STATUS_ORDER;
        end else begin
          out_between_d = sum[21:0];
        end
      end
      S_OFS: begin
        if ((cmd_q == CMD_AFTER && sum > {1'b0, LAST_SERIAL}) ||
            (cmd_q == CMD_BEFORE && !sum[22])) begin
          state_d      = S_IDLE;
          done_d       = 1'b1;
          out_status_d = STATUS_RANGE;
        end else begin
          acc_d   = sum[21:0];
          yr_d    = 14'd1;
          state_d = S_FYR;
        end
      end
      S_FYR: begin
        if (sum[22]) begin
          acc_d = sum[21:0];
          yr_d  = yr_q + 14'd1;
        end else begin
          mo_d    = 4'd1;
          state_d = S_FMO;
        end
      end
      S_FMO: begin
        if ((mo_q != MONTH_MAX) && sum[22]) begin
          acc_d = sum[21:0];
          mo_d  = mo_q + 4'd1;
        end else begin
          state_d     = S_IDLE;
          done_d      = 1'b1;
          out_day_d   = acc_q[4:0] + 5'd1;
          out_month_d = mo_q;
          out_year_d  = yr_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A fresh request starts with a clean result; every field not produced
    // by the command reads as zero.
    if (state_q == S_IDLE && accept) begin
      out_between_d = '0;
      out_day_d     = '0;
      out_month_d   = '0;
      out_year_d    = '0;
      out_status_d  = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      side_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      sd_q  <= start_day_i;
      sm_q  <= start_month_i;
      sy_q  <= start_year_i;
      ed_q  <= end_day_i;
      em_q  <= end_month_i;
      ey_q  <= end_year_i;
      cnt_q <= day_count_i;
    end
    acc_q         <= acc_d;
    s0_q          <= s0_d;
    yr_q          <= yr_d;
    mo_q          <= mo_d;
    out_between_q <= out_between_d;
    out_day_q     <= out_day_d;
    out_month_q   <= out_month_d;
    out_year_q    <= out_year_d;
    out_status_q  <= out_status_d;
  end

  assign done_o         = done_q;
  assign days_between_o = out_between_q;
  assign result_day_o   = out_day_q;
  assign result_month_o = out_month_q;
  assign result_year_o  = out_year_q;
  assign status_o       = out_status_q;

  // A result is only ever presented once the sequencer has returned to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while the sequencer is busy");

  // Every request passes through a check state, so strobes never touch.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // An accepted request always occupies the sequencer in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but sequencer not busy");

  // Error results carry nothing but the status code.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STATUS_OK) |->
      (days_between_o == '0 && result_day_o == '0 &&
       result_month_o == '0 && result_year_o == '0))
    else $error("error result carries a nonzero field");

  // A successful date result is never paired with a day count.
  a_ok_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_OK && result_year_o != '0) |->
      (days_between_o == '0 && result_day_o != '0 && result_month_o != '0))
    else $error("date result mixed with a day count");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import cda_pkg::*;

  localparam int unsigned HALF_PERIOD = 5;
  localparam int unsigned RESET_CYCLES = 10;
  // The slowest request walks nearly every year twice; the limit leaves a wide margin.
  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_PER_PHASE = 25;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned DAYS_PER_400Y = 146097;
  localparam int unsigned DAYS_PER_100Y = 36524;
  localparam int unsigned DAYS_PER_4Y = 1461;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned SMALL_YEAR_MAX = 600;

  typedef struct packed {
    logic [1:0] cmd;
    day_t       start_day;
    month_t     start_month;
    year_t      start_year;
    day_t       end_day;
    month_t     end_month;
    year_t      end_year;
    count_t     day_count;
  } request_t;

  typedef struct packed {
    count_t     days_between;
    day_t       result_day;
    month_t     result_month;
    year_t      result_year;
    logic [1:0] status;
  } date_result_t;

  typedef struct packed {
    day_t   day;
    month_t month;
    year_t  year;
  } date_t;

  // A row of the directed table; typed rows carry their answer, the rest are predicted.
  typedef struct {
    request_t     req;
    bit           typed;
    date_result_t answer;
  } table_row_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  logic [1:0] cmd_i = '0;
  day_t   start_day_i = '0;
  month_t start_month_i = '0;
  year_t  start_year_i = '0;
  day_t   end_day_i = '0;
  month_t end_month_i = '0;
  year_t  end_year_i = '0;
  count_t day_count_i = '0;
  logic   done_o;
  count_t days_between_o;
  day_t   result_day_o;
  month_t result_month_o;
  year_t  result_year_o;
  logic [1:0] status_o;

  date_result_t pending_results[$];
  date_result_t oldest;
  table_row_t   stimulus_table[$];
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  sender_gap_pct = 0;

  calendar_date_arithmetic_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .start_day_i    (start_day_i),
    .start_month_i  (start_month_i),
    .start_year_i   (start_year_i),
    .end_day_i      (end_day_i),
    .end_month_i    (end_month_i),
    .end_year_i     (end_year_i),
    .day_count_i    (day_count_i),
    .done_o         (done_o),
    .days_between_o (days_between_o),
    .result_day_o   (result_day_o),
    .result_month_o (result_month_o),
    .result_year_o  (result_year_o),
    .status_o       (status_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Calendar arithmetic used to predict each result.
  // ---------------------------------------------------------------------------

  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    case (m)
      2:             return is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic bit date_ok(int unsigned d, int unsigned m, int unsigned y);
    if (y < 1 || y > YEAR_MAX || m < 1 || m > MONTH_MAX) return 1'b0;
    return (d >= 1) && (d <= month_days(m, y));
  endfunction

  // Days elapsed since 0001-01-01 for a valid date.
  function automatic int unsigned day_number(int unsigned d, int unsigned m, int unsigned y);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = DAYS_PER_YEAR * p + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++) n += month_days(k, y);
    return n + d - 1;
  endfunction

  // Inverse of day_number: split into 400, 100, 4 and 1 year blocks, then months.
  function automatic date_t date_of(int unsigned n);
    date_t       dt;
    int unsigned q400, q100, q4, q1, yr, mo;
    q400 = n / DAYS_PER_400Y;
    n = n % DAYS_PER_400Y;
    q100 = n / DAYS_PER_100Y;
    if (q100 > 3) q100 = 3;
    n -= q100 * DAYS_PER_100Y;
    q4 = n / DAYS_PER_4Y;
    n = n % DAYS_PER_4Y;
    q1 = n / DAYS_PER_YEAR;
    if (q1 > 3) q1 = 3;
    n -= q1 * DAYS_PER_YEAR;
    yr = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
    mo = 1;
    while (mo < MONTH_MAX && n >= month_days(mo, yr)) begin
      n -= month_days(mo, yr);
      mo++;
    end
    dt.day = day_t'(n + 1);
    dt.month = month_t'(mo);
    dt.year = year_t'(yr);
    return dt;
  endfunction

  function automatic date_result_t predict_result(request_t r);
    date_result_t res;
    date_t        dt;
    int unsigned  s0, s1;
    res = '0;
    s1 = 0;
    if (r.cmd == CMD_UNUSED || !date_ok(r.start_day, r.start_month, r.start_year)) begin
      res.status = STATUS_INVALID;
    end else if (r.cmd == CMD_BETWEEN) begin
      if (!date_ok(r.end_day, r.end_month, r.end_year)) begin
        res.status = STATUS_INVALID;
      end else begin
        s0 = day_number(r.start_day, r.start_month, r.start_year);
        s1 = day_number(r.end_day, r.end_month, r.end_year);
        if (s1 < s0) res.status = STATUS_ORDER;
        else res.days_between = count_t'(s1 - s0);
      end
    end else begin
      s0 = day_number(r.start_day, r.start_month, r.start_year);
      if (r.cmd == CMD_AFTER) begin
        if (s0 + r.day_count > LAST_SERIAL) res.status = STATUS_RANGE;
        else s1 = s0 + r.day_count;
      end else begin
        if (r.day_count > s0) res.status = STATUS_RANGE;
        else s1 = s0 - r.day_count;
      end
      if (res.status == STATUS_OK) begin
        dt = date_of(s1);
        res.result_day = dt.day;
        res.result_month = dt.month;
        res.result_year = dt.year;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table.
  // ---------------------------------------------------------------------------

  function automatic request_t mk_req(logic [1:0] cmd, int unsigned sd, int unsigned sm,
                                      int unsigned sy, int unsigned ed, int unsigned em,
                                      int unsigned ey, int unsigned cnt);
    request_t r;
    r.cmd = cmd;
    r.start_day = day_t'(sd);
    r.start_month = month_t'(sm);
    r.start_year = year_t'(sy);
    r.end_day = day_t'(ed);
    r.end_month = month_t'(em);
    r.end_year = year_t'(ey);
    r.day_count = count_t'(cnt);
    return r;
  endfunction

  function automatic date_result_t status_only(logic [1:0] st);
    date_result_t res;
    res = '0;
    res.status = st;
    return res;
  endfunction

  function automatic date_result_t date_answer(int unsigned d, int unsigned m, int unsigned y);
    date_result_t res;
    res = '0;
    res.result_day = day_t'(d);
    res.result_month = month_t'(m);
    res.result_year = year_t'(y);
    return res;
  endfunction

  function automatic date_result_t count_answer(int unsigned n);
    date_result_t res;
    res = '0;
    res.days_between = count_t'(n);
    return res;
  endfunction

  task automatic add_row(request_t r, bit typed, date_result_t answer);
    table_row_t row;
    row.req = r;
    row.typed = typed;
    row.answer = answer;
    stimulus_table.push_back(row);
  endtask

  task automatic build_table();
    // Full span of the calendar, forward and backward; the ignored count is all ones.
    add_row(mk_req(CMD_BETWEEN, 1, 1, 1, 31, 12, 9999, 4194303), 1, count_answer(LAST_SERIAL));
    add_row(mk_req(CMD_BETWEEN, 31, 12, 9999, 1, 1, 1, 0), 1, status_only(STATUS_ORDER));
    add_row(mk_req(CMD_BETWEEN, 15, 6, 2000, 15, 6, 2000, 0), 1, count_answer(0));
    add_row(mk_req(CMD_BETWEEN, 28, 2, 1900, 1, 3, 1900, 0), 0, '0);
    add_row(mk_req(CMD_BETWEEN, 1, 1, 2000, 1, 1, 2001, 0), 0, '0);
    // Stepping at the two ends of the calendar; end fields here are ignored garbage.
    add_row(mk_req(CMD_AFTER, 31, 12, 9999, 31, 15, 16383, 0), 1, date_answer(31, 12, 9999));
    add_row(mk_req(CMD_AFTER, 31, 12, 9999, 0, 0, 0, 1), 1, status_only(STATUS_RANGE));
    add_row(mk_req(CMD_AFTER, 1, 1, 1, 0, 0, 0, 4194303), 1, status_only(STATUS_RANGE));
    add_row(mk_req(CMD_AFTER, 1, 1, 1, 0, 0, 0, LAST_SERIAL), 1, date_answer(31, 12, 9999));
    add_row(mk_req(CMD_BEFORE, 1, 1, 1, 0, 0, 0, 1), 1, status_only(STATUS_RANGE));
    add_row(mk_req(CMD_BEFORE, 1, 1, 1, 0, 0, 0, 0), 1, date_answer(1, 1, 1));
    add_row(mk_req(CMD_BEFORE, 31, 12, 9999, 0, 0, 0, LAST_SERIAL), 1, date_answer(1, 1, 1));
    // Leap day handling, including century years.
    add_row(mk_req(CMD_AFTER, 28, 2, 2024, 0, 0, 0, 1), 0, '0);
    add_row(mk_req(CMD_AFTER, 28, 2, 2100, 0, 0, 0, 1), 0, '0);
    add_row(mk_req(CMD_BEFORE, 1, 3, 2000, 0, 0, 0, 1), 0, '0);
    add_row(mk_req(CMD_AFTER, 29, 2, 2000, 0, 0, 0, 365), 0, '0);
    add_row(mk_req(CMD_AFTER, 31, 12, 2023, 0, 0, 0, 1), 0, '0);
    // Invalid dates and the unused command.
    add_row(mk_req(CMD_BETWEEN, 29, 2, 1900, 1, 1, 2000, 0), 1, status_only(STATUS_INVALID));
    add_row(mk_req(CMD_UNUSED, 1, 1, 2000, 1, 1, 2000, 5), 1, status_only(STATUS_INVALID));
    add_row(mk_req(CMD_AFTER, 0, 1, 1, 0, 0, 0, 1), 1, status_only(STATUS_INVALID));
    add_row(mk_req(CMD_BEFORE, 31, 4, 2020, 0, 0, 0, 1), 1, status_only(STATUS_INVALID));
    add_row(mk_req(CMD_AFTER, 1, 0, 2020, 0, 0, 0, 1), 1, status_only(STATUS_INVALID));
    add_row(mk_req(CMD_BETWEEN, 1, 1, 2000, 31, 15, 16383, 0), 1, status_only(STATUS_INVALID));
    add_row(mk_req(CMD_AFTER, 31, 15, 16383, 0, 0, 0, 1), 1, status_only(STATUS_INVALID));
    add_row(mk_req(CMD_BEFORE, 1, 1, 0, 0, 0, 0, 1), 1, status_only(STATUS_INVALID));
  endtask

  // ---------------------------------------------------------------------------
  // Random requests. Years stay small most of the time because the core walks
  // one year per cycle; a few requests span the whole calendar.
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_year();
    if ($urandom_range(99) < 8) return $urandom_range(YEAR_MAX, 1);
    return $urandom_range(SMALL_YEAR_MAX, 1);
  endfunction

  function automatic int unsigned pick_day(int unsigned m, int unsigned y);
    if ($urandom_range(99) < 25) return month_days(m, y);
    return $urandom_range(month_days(m, y), 1);
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned sd, sm, sy, ey, sn, sel, span;
    // Fields not used by the command carry random bits.
    r.cmd = 2'($urandom);
    r.start_day = day_t'($urandom);
    r.start_month = month_t'($urandom);
    r.start_year = year_t'($urandom);
    r.end_day = day_t'($urandom);
    r.end_month = month_t'($urandom);
    r.end_year = year_t'($urandom);
    r.day_count = count_t'($urandom);
    // A slice of the requests is pure noise, mostly invalid dates.
    if ($urandom_range(99) < 10) return r;

    sel = $urandom_range(99);
    if (sel < 3) r.cmd = CMD_UNUSED;
    else if (sel < 35) r.cmd = CMD_BETWEEN;
    else if (sel < 68) r.cmd = CMD_AFTER;
    else r.cmd = CMD_BEFORE;

    sy = pick_year();
    sm = $urandom_range(MONTH_MAX, 1);
    sd = pick_day(sm, sy);
    r.start_day = day_t'(sd);
    r.start_month = month_t'(sm);
    r.start_year = year_t'(sy);
    sn = day_number(sd, sm, sy);

    sel = $urandom_range(99);
    case (r.cmd)
      CMD_BETWEEN: begin
        if (sel < 10) begin
          r.end_day = r.start_day;
          r.end_month = r.start_month;
          r.end_year = r.start_year;
        end else begin
          // Mostly a later end date; otherwise anywhere, so the order check fires too.
          if (sel < 75) begin
            span = sy + $urandom_range(60);
            ey = (span > YEAR_MAX) ? YEAR_MAX : span;
          end else begin
            ey = pick_year();
          end
          r.end_year = year_t'(ey);
          r.end_month = month_t'($urandom_range(MONTH_MAX, 1));
          r.end_day = day_t'(pick_day(r.end_month, ey));
        end
      end
      CMD_AFTER: begin
        if (sel < 15) r.day_count = count_t'($urandom_range(400));
        else if (sel < 85) r.day_count = count_t'($urandom_range(120000));
      end
      CMD_BEFORE: begin
        if (sel < 15) r.day_count = count_t'($urandom_range(400));
        else if (sel < 85) r.day_count = count_t'($urandom_range(sn));
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Starts and ends at a rising edge; start drops only when the
  // next request is delayed by a gap.
  // ---------------------------------------------------------------------------

  task automatic issue_request(request_t r, bit typed, date_result_t answer);
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= r.cmd;
    start_day_i <= r.start_day;
    start_month_i <= r.start_month;
    start_year_i <= r.start_year;
    end_day_i <= r.end_day;
    end_month_i <= r.end_month;
    end_year_i <= r.end_year;
    day_count_i <= r.day_count;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // The request was taken at this edge.
    pending_results.push_back(typed ? answer : predict_result(r));
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Every result is a one-cycle strobe and is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("days_between", oldest.days_between, days_between_o);
        check_field("result_day", oldest.result_day, result_day_o);
        check_field("result_month", oldest.result_month, result_month_o);
        check_field("result_year", oldest.result_year, result_year_o);
        check_field("status", oldest.status, status_o);
      end
    end
  end

  // Counts cycles in which neither a request nor a result moves.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    build_table();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_gap_pct = 31;
    foreach (stimulus_table[i]) begin
      issue_request(stimulus_table[i].req, stimulus_table[i].typed, stimulus_table[i].answer);
    end
    repeat (RANDOM_PER_PHASE) issue_request(random_request(), 1'b0, '0);

    sender_gap_pct = 48;
    repeat (RANDOM_PER_PHASE) issue_request(random_request(), 1'b0, '0);

    sender_gap_pct = 0;
    repeat (RANDOM_PER_PHASE) issue_request(random_request(), 1'b0, '0);
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cda_pkg.sv
sv/calendar_date_arithmetic_core.sv
verif/testbench.sv
